/* sv/uarpc_pkg.sv */
// Package for the user access region policy check.
// Holds register indexes, mode codes, reset values and shared structs.
// No dependencies.
package uarpc_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned TaskW = 32;
  localparam int unsigned WinW  = 48;
  localparam int unsigned ModeW = 3;
  localparam int unsigned FlagW = 2;
  localparam int unsigned CfgIdxW = 3;

  // Addresses at or above this value are outside the canonical user half.
  localparam logic [AddrW-1:0] CanonLimit = 64'h0000_8000_0000_0000;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegSystemMode    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegUserStart     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegUserEnd       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBlockedStart  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBlockedEnd    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPersonalStart = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPersonalEnd   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDelegation    = 3'd7;

  // System mode codes.
  localparam logic [ModeW-1:0] ModeUnset      = 3'd0;
  localparam logic [ModeW-1:0] ModePrivate    = 3'd1;
  localparam logic [ModeW-1:0] ModeEnterprise = 3'd2;
  localparam logic [ModeW-1:0] ModeHybrid     = 3'd3;
  localparam logic [ModeW-1:0] ModeLocked     = 3'd4;

  // Delegation flag bit positions.
  localparam int unsigned FlagAwaitEnroll = 0;
  localparam int unsigned FlagDelegated   = 1;

  // Reset values of the window registers.
  localparam logic [WinW-1:0] UserStartRst     = 48'h0000_0000_0000;
  localparam logic [WinW-1:0] UserEndRst       = 48'h8000_0000_0000;
  localparam logic [WinW-1:0] BlockedStartRst  = 48'h6000_0000_0000;
  localparam logic [WinW-1:0] BlockedEndRst    = 48'h7F00_0000_0000;
  localparam logic [WinW-1:0] PersonalStartRst = 48'h7000_0000_0000;
  localparam logic [WinW-1:0] PersonalEndRst   = 48'h7F00_0000_0000;

  typedef struct packed {
    logic [ModeW-1:0] system_mode;
    logic [WinW-1:0]  user_base;
    logic [WinW-1:0]  user_limit;
    logic [WinW-1:0]  blocked_window_start;
    logic [WinW-1:0]  blocked_window_end;
    logic [WinW-1:0]  personal_window_start;
    logic [WinW-1:0]  personal_window_end;
    logic [FlagW-1:0] delegation_flags;
  } cfg_t;

  typedef struct packed {
    logic permitted;
    logic log_violation;
  } verdict_t;

endpackage

/* sv/uarpc_if.sv */
// Stream interfaces for the request and response channels.
// Depends on uarpc_pkg for field widths.
interface uarpc_req_if;
  logic                           valid;
  logic                           ready;
  logic [uarpc_pkg::AddrW-1:0]    addr;
  logic [uarpc_pkg::AddrW-1:0]    size;
  logic                           is_ai;
  logic [uarpc_pkg::TaskW-1:0]    task_id;

  modport source (output valid, output addr, output size, output is_ai,
                  output task_id, input ready);
  modport sink   (input valid, input addr, input size, input is_ai,
                  input task_id, output ready);
endinterface

interface uarpc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           permitted;
  logic                           violation_logged;
  logic [uarpc_pkg::AddrW-1:0]    violation_count;
  logic [uarpc_pkg::TaskW-1:0]    last_task;
  logic [uarpc_pkg::AddrW-1:0]    last_address;

  modport source (output valid, output permitted, output violation_logged,
                  output violation_count, output last_task, output last_address,
                  input ready);
  modport sink   (input valid, input permitted, input violation_logged,
                  input violation_count, input last_task, input last_address,
                  output ready);
endinterface

/* sv/uarpc_check.sv */
// Combinational policy decision for one access request.
// Base range check followed by the mode-dependent region policy.
// Depends on uarpc_pkg.
module uarpc_check (
  input  logic [uarpc_pkg::AddrW-1:0] addr,
  input  logic [uarpc_pkg::AddrW-1:0] size,
  input  logic                        is_ai,
  input  uarpc_pkg::cfg_t             cfg,
  output uarpc_pkg::verdict_t         verdict
);

  logic [uarpc_pkg::AddrW:0]   sum;
  logic [uarpc_pkg::AddrW-1:0] acc_end;
  logic [uarpc_pkg::AddrW-1:0] us_start, us_end;
  logic [uarpc_pkg::AddrW-1:0] bw_start, bw_end, pw_start, pw_end;
  logic base_ok;
  logic b_start_in, b_end_in, b_spans;
  logic p_start_in, p_end_in, p_spans;

  assign sum      = {1'b0, addr} + {1'b0, size};
  assign acc_end  = sum[uarpc_pkg::AddrW-1:0];
  assign us_start = {16'd0, cfg.user_base};
  assign us_end   = {16'd0, cfg.user_limit};
  assign bw_start = {16'd0, cfg.blocked_window_start};
  assign bw_end   = {16'd0, cfg.blocked_window_end};
  assign pw_start = {16'd0, cfg.personal_window_start};
  assign pw_end   = {16'd0, cfg.personal_window_end};

  // The carry out of the sum flags a range that wraps past the top of memory.
  assign base_ok = (size != '0) && !sum[uarpc_pkg::AddrW] && (addr >= us_start) &&
                   (acc_end <= us_end) && (addr < uarpc_pkg::CanonLimit);

  assign b_start_in = (addr >= bw_start) && (addr < bw_end);
  assign b_end_in   = (acc_end > bw_start) && (acc_end <= bw_end);
  assign b_spans    = (addr < bw_start) && (acc_end > bw_end);
  assign p_start_in = (addr >= pw_start) && (addr < pw_end);
  assign p_end_in   = (acc_end > pw_start) && (acc_end <= pw_end);
  assign p_spans    = (addr < pw_start) && (acc_end > pw_end);

  always_comb begin
    verdict.permitted     = 1'b1;
    verdict.log_violation = 1'b0;
    if (!base_ok) begin
      verdict.permitted = 1'b0;
    end else begin
      case (cfg.system_mode)
        uarpc_pkg::ModeLocked: begin
          if (b_start_in || b_end_in || b_spans) begin
            verdict.permitted     = 1'b0;
            verdict.log_violation = 1'b1;
          end
        end
        uarpc_pkg::ModeHybrid: begin
          // Pending enrollment blocks starts inside the personal window; without
          // delegation any start or end inside it is blocked as well.
          if ((cfg.delegation_flags[uarpc_pkg::FlagAwaitEnroll] && p_start_in) ||
              (!cfg.delegation_flags[uarpc_pkg::FlagDelegated] &&
               (p_start_in || p_end_in))) begin
            verdict.permitted     = 1'b0;
            verdict.log_violation = 1'b1;
          end
        end
        uarpc_pkg::ModePrivate: begin
          if (is_ai && (p_start_in || p_end_in || p_spans)) begin
            verdict.permitted = 1'b0;
          end
        end
        default: begin
          verdict.permitted = 1'b1;
        end
      endcase
    end
  end

endmodule

/* sv/user_access_region_policy_check_core.sv */
// Top level of the user access region policy check.
// Depends on uarpc_pkg, uarpc_req_if, uarpc_rsp_if and uarpc_check.
//
// Usage:
//   in_req carries one access request per transaction (addr, size, is_ai,
//   task_id). out_rsp returns one response per request, in order: the
//   permit bit, whether the denial was logged, and the violation counter,
//   last violating task and last violating address after that request.
//   cfg_we/cfg_index/cfg_wdata write one configuration register per cycle;
//   write only while no request is in flight.
// Path: a request accepted at an edge is registered in the input stage, its
//   policy verdict is computed combinationally from that stage, and the
//   response is registered in the output stage once that stage can load.
// Throughput: one request per cycle while out_rsp.ready stays high, set by
//   the single register stage on each side of the check logic.
// Stalls: when out_rsp.ready is low the response holds; one more request
//   can be accepted into the input stage, after which in_req.ready drops.
// Reset: configuration returns to its defaults, the violation counter and
//   the recorded task and address clear, and both stages empty.
module user_access_region_policy_check_core (
  input  logic                               clk,
  input  logic                               rst_n,
  uarpc_req_if.sink                          in_req,
  uarpc_rsp_if.source                        out_rsp,
  input  logic                               cfg_we,
  input  logic [uarpc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [uarpc_pkg::WinW-1:0]         cfg_wdata
);

  uarpc_pkg::cfg_t cfg_r;

  logic                        s1_valid_r;
  logic [uarpc_pkg::AddrW-1:0] s1_addr_r, s1_size_r;
  logic                        s1_is_ai_r;
  logic [uarpc_pkg::TaskW-1:0] s1_task_r;

  logic                        out_valid_r;
  logic                        permitted_r, logged_r;
  logic [uarpc_pkg::AddrW-1:0] count_r, count_nxt;
  logic [uarpc_pkg::TaskW-1:0] last_task_r, last_task_nxt;
  logic [uarpc_pkg::AddrW-1:0] last_addr_r, last_addr_nxt;

  uarpc_pkg::verdict_t verdict;
  logic out_load, in_load;

  assign out_load     = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_load      = in_req.valid && in_req.ready;
  assign in_req.ready = !s1_valid_r || !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.system_mode           <= uarpc_pkg::ModeUnset;
      cfg_r.user_base             <= uarpc_pkg::UserStartRst;
      cfg_r.user_limit            <= uarpc_pkg::UserEndRst;
      cfg_r.blocked_window_start  <= uarpc_pkg::BlockedStartRst;
      cfg_r.blocked_window_end    <= uarpc_pkg::BlockedEndRst;
      cfg_r.personal_window_start <= uarpc_pkg::PersonalStartRst;
      cfg_r.personal_window_end   <= uarpc_pkg::PersonalEndRst;
      cfg_r.delegation_flags      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        uarpc_pkg::RegSystemMode:
          cfg_r.system_mode <= cfg_wdata[uarpc_pkg::ModeW-1:0];
        uarpc_pkg::RegUserStart:     cfg_r.user_base             <= cfg_wdata;
        uarpc_pkg::RegUserEnd:       cfg_r.user_limit            <= cfg_wdata;
        uarpc_pkg::RegBlockedStart:  cfg_r.blocked_window_start  <= cfg_wdata;
        uarpc_pkg::RegBlockedEnd:    cfg_r.blocked_window_end    <= cfg_wdata;
        uarpc_pkg::RegPersonalStart: cfg_r.personal_window_start <= cfg_wdata;
        uarpc_pkg::RegPersonalEnd:   cfg_r.personal_window_end   <= cfg_wdata;
        uarpc_pkg::RegDelegation:
          cfg_r.delegation_flags <= cfg_wdata[uarpc_pkg::FlagW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_addr_r  <= in_req.addr;
      s1_size_r  <= in_req.size;
      s1_is_ai_r <= in_req.is_ai;
      s1_task_r  <= in_req.task_id;
    end
  end

  uarpc_check u_check (
    .addr    (s1_addr_r),
    .size    (s1_size_r),
    .is_ai   (s1_is_ai_r),
    .cfg     (cfg_r),
    .verdict (verdict)
  );

  // The violation state doubles as the response payload: it only moves when
  // a new response is loaded, so it always reflects the response on display.
  always_comb begin
    count_nxt     = count_r;
    last_task_nxt = last_task_r;
    last_addr_nxt = last_addr_r;
    if (verdict.log_violation) begin
      count_nxt     = count_r + 64'd1;
      last_task_nxt = s1_task_r;
      last_addr_nxt = s1_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      last_task_r <= '0;
      last_addr_r <= '0;
    end else begin
      if (!out_valid_r || out_rsp.ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (out_load) begin
        count_r     <= count_nxt;
        last_task_r <= last_task_nxt;
        last_addr_r <= last_addr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      permitted_r <= verdict.permitted;
      logged_r    <= verdict.log_violation;
    end
  end

  assign out_rsp.valid            = out_valid_r;
  assign out_rsp.permitted        = permitted_r;
  assign out_rsp.violation_logged = logged_r;
  assign out_rsp.violation_count  = count_r;
  assign out_rsp.last_task        = last_task_r;
  assign out_rsp.last_address     = last_addr_r;

`ifndef NO_ASSERTIONS
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && verdict.log_violation |=> count_r == $past(count_r) + 64'd1)
    else $error("violation counter did not advance on a logged denial");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_load && verdict.log_violation) |=> $stable(count_r))
    else $error("violation counter moved without a logged denial");

  a_logged_denied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && logged_r |-> !permitted_r)
    else $error("logged response reports the access as permitted");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_req.ready |-> s1_valid_r && out_valid_r && !out_rsp.ready)
    else $error("input stalled while the pipeline has room");

  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_rsp.ready |=> out_valid_r && $stable(permitted_r) &&
      $stable(last_addr_r))
    else $error("stalled response changed");
`endif

endmodule
